/* hdl/abig_pkg.sv */
`default_nettype none
package abig_pkg;

    localparam int DataW   = 8;
    localparam int AddrW   = 16;
    localparam int ModeW   = 3;
    localparam int KindW   = 3;
    localparam int SwitchW = 4;
    localparam int PalIdxW = 6;
    localparam int CfgIdxW = 1;
    localparam int InDataW  = 40;
    localparam int OutDataW = 40;

    localparam logic [ModeW-1:0] MODE_READ   = 3'd0;
    localparam logic [ModeW-1:0] MODE_WRITE  = 3'd1;
    localparam logic [ModeW-1:0] MODE_VBLANK = 3'd2;
    localparam logic [ModeW-1:0] MODE_POLL   = 3'd3;
    localparam logic [ModeW-1:0] MODE_SWITCH = 3'd4;

    localparam logic [KindW-1:0] KIND_NONE    = 3'd0;
    localparam logic [KindW-1:0] KIND_READ    = 3'd1;
    localparam logic [KindW-1:0] KIND_SOUND   = 3'd2;
    localparam logic [KindW-1:0] KIND_TX      = 3'd3;
    localparam logic [KindW-1:0] KIND_PALETTE = 3'd4;
    localparam logic [KindW-1:0] KIND_IRQ     = 3'd5;
    localparam logic [KindW-1:0] KIND_NMI     = 3'd6;
    localparam logic [KindW-1:0] KIND_OVERLAY = 3'd7;

    localparam logic [CfgIdxW-1:0] CFG_DIP_A = 1'd0;
    localparam logic [CfgIdxW-1:0] CFG_DIP_B = 1'd1;

    localparam logic [DataW-1:0] DIP_A_RESET = 8'h00;
    localparam logic [DataW-1:0] DIP_B_RESET = 8'h47;

    localparam logic [AddrW-1:0] ADDR_PANEL     = 16'h1000;
    localparam logic [AddrW-1:0] ADDR_COIN_DIPA = 16'h1001;
    localparam logic [AddrW-1:0] ADDR_DIPB      = 16'h1002;
    localparam logic [AddrW-1:0] ADDR_VBLANK    = 16'h1003;
    localparam logic [AddrW-1:0] ADDR_SOUND     = 16'h1004;
    localparam logic [AddrW-1:0] ADDR_ACIA_CTRL = 16'h1006;
    localparam logic [AddrW-1:0] ADDR_ACIA_DATA = 16'h1007;
    localparam logic [AddrW-1:0] ADDR_PAL_FIRST = 16'h1800;
    localparam logic [AddrW-1:0] ADDR_PAL_LAST  = 16'h1837;

    typedef struct packed {
        logic [ModeW-1:0]   mode;
        logic [AddrW-1:0]   address;
        logic [DataW-1:0]   write_data;
        logic               rx_ready;
        logic [DataW-1:0]   rx_byte;
        logic [SwitchW-1:0] switch_id;
        logic               pressed;
    } t_item;

    typedef struct packed {
        logic [DataW-1:0] red;
        logic [DataW-1:0] green;
        logic [DataW-1:0] blue;
    } t_color;

    typedef struct packed {
        logic [KindW-1:0]   result_kind;
        logic [DataW-1:0]   data_byte;
        logic [PalIdxW-1:0] palette_index;
        t_color             color;
    } t_result;

    typedef struct packed {
        logic               we;
        logic [CfgIdxW-1:0] index;
        logic [DataW-1:0]   data;
    } t_cfg;

endpackage
`default_nettype wire

/* hdl/arcade_board_io_glue_core.sv */
// I/O glue for the main processor of a laserdisc arcade board.
// The slave stream carries one event per item: tuser holds the mode (bus read,
// bus write, vblank tick, serial poll or switch change) and tdata holds the
// address, write data, serial receive flag and byte, switch id and press flag.
// Every accepted item produces exactly one item on the master stream, whose
// tuser holds the result kind and whose tdata holds the data byte, palette
// index and decoded red, green and blue.
// An item is taken into an input register, decoded combinationally against the
// switch, vblank and serial status state, and written to an output register.
// The result reaches the master side after both the input and output registers,
// and one item is accepted every cycle while the master side keeps tready high.
// When the master side stalls, the output register holds its item and the
// input register fills; then s_tready drops until the master side takes one.
// The user writes the DIP banks through the configuration port only while no item
// is in flight; the block does not enforce it. A synchronous active-low reset
// empties both registers, sets all switch bits to released, clears the vblank
// flag and serial status, and loads the DIP banks with their defaults.
`default_nettype none
module arcade_board_io_glue_core (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [abig_pkg::CfgIdxW-1:0]    i_cfg_index,
    input  wire logic [abig_pkg::DataW-1:0]      i_cfg_data,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // Fields from bit 0: address, write_data, rx_ready, rx_byte, switch_id, pressed.
    input  wire logic [abig_pkg::InDataW-1:0]    s_axis_tdata,
    // Fields from bit 0: mode.
    input  wire logic [abig_pkg::ModeW-1:0]      s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // Fields from bit 0: data_byte, palette_index, red, green, blue.
    output logic [abig_pkg::OutDataW-1:0]        m_axis_tdata,
    // Fields from bit 0: result_kind.
    output logic [abig_pkg::KindW-1:0]           m_axis_tuser
);
    import abig_pkg::*;

    logic    r_in_valid;
    t_item   r_in_item;
    logic    r_out_valid;
    t_result r_out_res;
    logic    advance;
    logic    fire;
    t_item   in_item;
    t_result result;
    t_cfg    cfg;

    assign in_item.mode       = s_axis_tuser;
    assign in_item.address    = s_axis_tdata[15:0];
    assign in_item.write_data = s_axis_tdata[23:16];
    assign in_item.rx_ready   = s_axis_tdata[24];
    assign in_item.rx_byte    = s_axis_tdata[32:25];
    assign in_item.switch_id  = s_axis_tdata[36:33];
    assign in_item.pressed    = s_axis_tdata[37];

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    assign advance       = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && advance;
    assign s_axis_tready = !r_in_valid || advance;

    abig_io u_io (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (fire),
        .i_item   (r_in_item),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_item <= in_item;
        end
        if (fire) begin
            r_out_res <= result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_res.result_kind;
    assign m_axis_tdata  = {2'b00, r_out_res.color.blue, r_out_res.color.green,
                            r_out_res.color.red, r_out_res.palette_index,
                            r_out_res.data_byte};

endmodule
`default_nettype wire

/* hdl/abig_palette.sv */
`default_nettype none
module abig_palette (
    input  wire logic [abig_pkg::DataW-1:0] i_write_data,
    output abig_pkg::t_color                o_color
);
    import abig_pkg::*;

    logic [DataW-1:0] v;

    function automatic logic [DataW-1:0] weigh3(input logic b0, input logic b1,
                                                 input logic b2);
        logic [DataW-1:0] s;
        s = (b0 ? 8'h21 : 8'h00) + (b1 ? 8'h47 : 8'h00) + (b2 ? 8'h97 : 8'h00);
        return s;
    endfunction

    assign v = ~i_write_data;

    always_comb begin
        o_color.red   = weigh3(v[0], v[1], v[2]);
        o_color.green = weigh3(v[3], v[4], v[5]);
        o_color.blue  = weigh3(1'b0, v[6], v[7]);
    end

endmodule
`default_nettype wire

/* hdl/abig_io.sv */
`default_nettype none
module abig_io (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire abig_pkg::t_cfg  i_cfg,
    input  wire logic            i_fire,
    input  wire abig_pkg::t_item i_item,
    output abig_pkg::t_result    o_result
);
    import abig_pkg::*;

    logic [DataW-1:0] r_dip_a;
    logic [DataW-1:0] r_dip_b;
    logic [DataW-1:0] r_panel, n_panel;
    logic [3:0]       r_coin, n_coin;
    logic             r_vblank, n_vblank;
    logic             r_rxf, n_rxf;
    logic             r_txe, n_txe;
    logic             r_irq, n_irq;
    logic [DataW-1:0] r_rx_pend, n_rx_pend;
    logic [DataW-1:0] r_rx_data, n_rx_data;

    logic [DataW-1:0] pmask;
    logic [3:0]       cmask;
    t_color           color;

    abig_palette u_palette (
        .i_write_data (i_item.write_data),
        .o_color      (color)
    );

    always_comb begin
        case (i_item.switch_id)
            4'd0:    begin pmask = 8'h02; cmask = 4'h0; end
            4'd1:    begin pmask = 8'h04; cmask = 4'h0; end
            4'd2:    begin pmask = 8'h08; cmask = 4'h0; end
            4'd3:    begin pmask = 8'h01; cmask = 4'h0; end
            4'd4:    begin pmask = 8'h00; cmask = 4'h2; end
            4'd5:    begin pmask = 8'h00; cmask = 4'h1; end
            4'd6:    begin pmask = 8'h40; cmask = 4'h0; end
            4'd7:    begin pmask = 8'h20; cmask = 4'h0; end
            4'd8:    begin pmask = 8'h10; cmask = 4'h0; end
            4'd9:    begin pmask = 8'h00; cmask = 4'h4; end
            4'd10:   begin pmask = 8'h00; cmask = 4'h8; end
            4'd11:   begin pmask = 8'h04; cmask = 4'h0; end
            default: begin pmask = 8'h00; cmask = 4'h0; end
        endcase
    end

    always_comb begin
        n_panel   = r_panel;
        n_coin    = r_coin;
        n_vblank  = r_vblank;
        n_rxf     = r_rxf;
        n_txe     = r_txe;
        n_irq     = r_irq;
        n_rx_pend = r_rx_pend;
        n_rx_data = r_rx_data;
        o_result  = '0;
        case (i_item.mode)
            MODE_READ: begin
                o_result.result_kind = KIND_READ;
                if (i_item.address == ADDR_PANEL) begin
                    o_result.data_byte = r_panel;
                end else if (i_item.address == ADDR_COIN_DIPA) begin
                    o_result.data_byte = {r_coin, ~r_dip_a[3:0]};
                end else if (i_item.address == ADDR_DIPB) begin
                    o_result.data_byte = ~r_dip_b;
                end else if (i_item.address == ADDR_VBLANK) begin
                    o_result.data_byte = {r_vblank, 7'd0};
                    n_vblank = 1'b0;
                end else if (i_item.address == ADDR_ACIA_CTRL) begin
                    o_result.data_byte = {r_irq, 5'd0, r_txe, r_rxf};
                end else if (i_item.address == ADDR_ACIA_DATA) begin
                    if (r_rxf) begin
                        n_rx_data = r_rx_pend;
                    end
                    o_result.data_byte = r_rxf ? r_rx_pend : r_rx_data;
                    n_irq = 1'b0;
                    n_rxf = 1'b0;
                end else begin
                    o_result.result_kind = KIND_NONE;
                end
            end
            MODE_WRITE: begin
                if (i_item.address == ADDR_SOUND) begin
                    o_result.result_kind = KIND_SOUND;
                    o_result.data_byte   = i_item.write_data;
                end else if (i_item.address == ADDR_ACIA_CTRL) begin
                    if (i_item.write_data[1:0] == 2'b11) begin
                        n_irq = 1'b0;
                        n_txe = 1'b1;
                        n_rxf = 1'b0;
                    end
                end else if (i_item.address == ADDR_ACIA_DATA) begin
                    n_irq = 1'b0;
                    n_txe = 1'b0;
                    o_result.result_kind = KIND_TX;
                    o_result.data_byte   = i_item.write_data;
                end else if (i_item.address >= ADDR_PAL_FIRST
                             && i_item.address <= ADDR_PAL_LAST) begin
                    o_result.result_kind   = KIND_PALETTE;
                    o_result.palette_index = i_item.address[PalIdxW-1:0];
                    o_result.color         = color;
                end else if (i_item.address[15:13] == 3'b001) begin
                    o_result.result_kind = KIND_OVERLAY;
                end
            end
            MODE_VBLANK: begin
                n_vblank = 1'b1;
            end
            MODE_POLL: begin
                if (i_item.rx_ready) begin
                    n_rx_pend = i_item.rx_byte;
                    n_irq = 1'b1;
                    n_txe = 1'b1;
                    n_rxf = 1'b1;
                    o_result.result_kind = KIND_IRQ;
                end else if (!r_rxf) begin
                    n_txe = 1'b1;
                end
            end
            MODE_SWITCH: begin
                if (i_item.pressed) begin
                    n_panel = r_panel & ~pmask;
                    n_coin  = r_coin & ~cmask;
                    if (i_item.switch_id == 4'd9 || i_item.switch_id == 4'd10) begin
                        o_result.result_kind = KIND_NMI;
                    end
                end else begin
                    n_panel = r_panel | pmask;
                    n_coin  = r_coin | cmask;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dip_a   <= DIP_A_RESET;
            r_dip_b   <= DIP_B_RESET;
            r_panel   <= 8'hFF;
            r_coin    <= 4'hF;
            r_vblank  <= 1'b0;
            r_rxf     <= 1'b0;
            r_txe     <= 1'b0;
            r_irq     <= 1'b0;
            r_rx_pend <= '0;
            r_rx_data <= '0;
        end else begin
            if (i_cfg.we) begin
                case (i_cfg.index)
                    CFG_DIP_A: r_dip_a <= i_cfg.data;
                    CFG_DIP_B: r_dip_b <= i_cfg.data;
                    default: begin
                    end
                endcase
            end
            if (i_fire) begin
                r_panel   <= n_panel;
                r_coin    <= n_coin;
                r_vblank  <= n_vblank;
                r_rxf     <= n_rxf;
                r_txe     <= n_txe;
                r_irq     <= n_irq;
                r_rx_pend <= n_rx_pend;
                r_rx_data <= n_rx_data;
            end
        end
    end

    a_panel_top: assert property (@(posedge i_clk) disable iff (!i_rst_n) r_panel[7])
        else $error("panel bit 7 cleared");

    a_vblank_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_READ && i_item.address == ADDR_VBLANK
        |=> !r_vblank)
        else $error("vblank flag not cleared by read");

    a_poll_irq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && i_item.mode == MODE_POLL && i_item.rx_ready
        |=> r_rxf && r_irq && r_txe)
        else $error("ready poll did not raise status");

    a_idle_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_fire |=> $stable(r_panel) && $stable(r_coin) && $stable(r_rx_pend))
        else $error("state changed without an item");

endmodule
`default_nettype wire
